// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define STRE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define STRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STRE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define STRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/stre_pkg.sv =====
`default_nettype none

package stre_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 5;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int IDX_W      = COL_W + 1;
    localparam int NR_W       = 5;
    localparam int NC_W       = 6;
    localparam int OBJ_W      = 4;
    localparam int RIDX_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_ROW  = 2'd2;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_DIV   = 3'd2,
        OP_ELIM  = 3'd3,
        OP_MAX   = 3'd4,
        OP_RATIO = 3'd5
    } t_op;

    typedef struct packed {
        t_op                       command;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          column;
        logic [ROW_W-1:0]          pivot_row;
        logic [COL_W-1:0]          denom_col;
        logic signed [DATA_W-1:0]  operand_value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0]  result_value;
        logic [RIDX_W-1:0]         result_index;
        logic                      found;
        logic                      not_positive;
        logic                      status;
    } t_out;

    typedef enum logic [2:0] {
        AS_RC, AS_RI, AS_PI, AS_ID, AS_IC, AS_CLR
    } t_asel;

    typedef enum logic [1:0] {
        WS_OP, WS_ZERO, WS_DIV, WS_ELIM
    } t_wsel;

    typedef enum logic [2:0] {
        RES_ERR, RES_OK, RES_READ, RES_MAX, RES_RATIO
    } t_res;

    typedef struct packed {
        logic              ld_req;
        t_asel             addr_sel;
        logic              mem_rd;
        logic              mem_wr;
        t_wsel             wr_sel;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] clr_addr;
        logic              ld_x;
        logic              ld_y;
        logic              ld_y_op;
        logic              ld_m;
        logic              mul;
        logic              div_start;
        logic              clr_best;
        logic              upd_max;
        logic              upd_rat;
        logic              rat_div;
        logic              res_ld;
        t_res              res_kind;
    } t_dp_cmd;

    typedef struct packed {
        t_op   cmd;
        logic  ok_rc;
        logic  ok_div;
        logic  op_one;
        logic  ok_elim;
        logic  ok_am;
        logic  ok_rt;
        logic  idx_lt_nc;
        logic  idx_lt_nr;
        logic  idx_is_obj;
        logic  rd_zero;
        logic  y_le0;
        logic  div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/stre_div.sv =====
`default_nettype none

module stre_div (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_start,
    input  wire logic signed [stre_pkg::DATA_W-1:0]      i_num,
    input  wire logic signed [stre_pkg::DATA_W-1:0]      i_den,
    output logic                                         o_done,
    output logic signed [stre_pkg::DATA_W-1:0]           o_quo
);

    localparam int DW    = stre_pkg::DATA_W;
    localparam int QW    = DW + stre_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(QW);
    localparam logic [QW-1:0] POS_LIM = QW'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (DW - 1));

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DW-1:0]         r_rem;
    logic [QW-1:0]         r_quo;
    logic [DW-1:0]         r_den;
    logic                  r_neg;
    logic signed [DW-1:0]  r_q;

    logic [DW-1:0] w_anum;
    logic [DW-1:0] w_aden;
    logic [DW:0]   w_trial;
    logic          w_ge;
    logic [DW:0]   w_diff;
    logic [QW-1:0] n_quo;
    logic [DW-1:0] n_rem;
    logic signed [DW-1:0] w_res;

    always_comb begin
        w_anum  = i_num[DW-1] ? (~i_num + DW'(1)) : i_num;
        w_aden  = i_den[DW-1] ? (~i_den + DW'(1)) : i_den;
        w_trial = {r_rem, r_quo[QW-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        n_quo   = {r_quo[QW-2:0], w_ge};
        if (r_neg) begin
            w_res = (n_quo > NEG_LIM) ? {1'b1, {(DW-1){1'b0}}}
                                      : (~n_quo[DW-1:0] + DW'(1));
        end else begin
            w_res = (n_quo > POS_LIM) ? {1'b0, {(DW-1){1'b1}}} : n_quo[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= {w_anum, {stre_pkg::FRAC_BITS{1'b0}}};
                r_den  <= w_aden;
                r_neg  <= i_num[DW-1] ^ i_den[DW-1];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q    <= w_res;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/stre_dp.sv =====
`default_nettype none

module stre_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire stre_pkg::t_dp_cmd                    i_cmd,
    output stre_pkg::t_dp_sts                         o_sts,
    input  wire stre_pkg::t_in                        i_in_data,
    input  wire logic                                 i_cfg_we,
    input  wire logic [stre_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [stre_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output stre_pkg::t_out                            o_out_data
);

    localparam int DW = stre_pkg::DATA_W;
    localparam logic signed [63:0] RND = (64'sd1 <<< stre_pkg::FRAC_BITS) - 64'sd1;
    localparam logic signed [DW-1:0] ONE = DW'(64'd1 << stre_pkg::FRAC_BITS);
    localparam logic [stre_pkg::NR_W-1:0] NR_MAX = stre_pkg::NR_W'(stre_pkg::MAX_ROWS);
    localparam logic [stre_pkg::NC_W-1:0] NC_MAX = stre_pkg::NC_W'(stre_pkg::MAX_COLS);

    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
        logic signed [DW-1:0] s;
        if (v > 64'sd2147483647) s = {1'b0, {(DW-1){1'b1}}};
        else if (v < -64'sd2147483648) s = {1'b1, {(DW-1){1'b0}}};
        else s = v[DW-1:0];
        return s;
    endfunction

    stre_pkg::t_in                  r_req;
    logic [stre_pkg::NR_W-1:0]      r_num_rows;
    logic [stre_pkg::NC_W-1:0]      r_num_cols;
    logic [stre_pkg::OBJ_W-1:0]     r_obj_row;
    logic [DW-1:0]                  r_mem [stre_pkg::DEPTH];
    logic signed [DW-1:0]           r_rdata;
    logic signed [DW-1:0]           r_x;
    logic signed [DW-1:0]           r_y;
    logic signed [DW-1:0]           r_m;
    logic signed [63:0]             r_prod;
    logic signed [DW-1:0]           r_best;
    logic [stre_pkg::RIDX_W-1:0]    r_bidx;
    logic                           r_have;
    stre_pkg::t_out                 r_out;

    logic [stre_pkg::NR_W-1:0]      w_nr;
    logic [stre_pkg::NC_W-1:0]      w_nc;
    logic [stre_pkg::ADDR_W-1:0]    w_addr;
    logic signed [DW-1:0]           w_wdata;
    logic signed [63:0]             w_q;
    logic signed [63:0]             w_ye;
    logic signed [DW-1:0]           w_elim;
    logic signed [DW-1:0]           w_cand;
    logic signed [DW-1:0]           w_quo;
    logic                           w_div_done;
    logic                           w_row_ok;
    logic                           w_prow_ok;
    logic                           w_col_ok;
    logic                           w_dcol_ok;
    stre_pkg::t_out                 w_res;

    stre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_x),
        .i_den   (r_y),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_nr = (r_num_rows > NR_MAX) ? NR_MAX : r_num_rows;
        w_nc = (r_num_cols > NC_MAX) ? NC_MAX : r_num_cols;
        w_row_ok  = ({1'b0, r_req.row} < w_nr);
        w_prow_ok = ({1'b0, r_req.pivot_row} < w_nr);
        w_col_ok  = ({1'b0, r_req.column} < w_nc);
        w_dcol_ok = ({1'b0, r_req.denom_col} < w_nc);

        unique case (i_cmd.addr_sel)
            stre_pkg::AS_RC:  w_addr = {r_req.row, r_req.column};
            stre_pkg::AS_RI:  w_addr = {r_req.row, i_cmd.idx[stre_pkg::COL_W-1:0]};
            stre_pkg::AS_PI:  w_addr = {r_req.pivot_row, i_cmd.idx[stre_pkg::COL_W-1:0]};
            stre_pkg::AS_ID:  w_addr = {i_cmd.idx[stre_pkg::ROW_W-1:0], r_req.denom_col};
            stre_pkg::AS_IC:  w_addr = {i_cmd.idx[stre_pkg::ROW_W-1:0], r_req.column};
            stre_pkg::AS_CLR: w_addr = i_cmd.clr_addr;
            default:          w_addr = i_cmd.clr_addr;
        endcase

        w_q    = (r_prod + (r_prod[63] ? RND : 64'sd0)) >>> stre_pkg::FRAC_BITS;
        w_ye   = {{(64-DW){r_y[DW-1]}}, r_y};
        w_elim = sat32(w_ye - w_q);

        unique case (i_cmd.wr_sel)
            stre_pkg::WS_OP:   w_wdata = r_req.operand_value;
            stre_pkg::WS_ZERO: w_wdata = '0;
            stre_pkg::WS_DIV:  w_wdata = w_quo;
            stre_pkg::WS_ELIM: w_wdata = w_elim;
            default:           w_wdata = '0;
        endcase

        w_cand = i_cmd.rat_div ? w_quo : r_x;

        w_res = '0;
        unique case (i_cmd.res_kind)
            stre_pkg::RES_ERR:  w_res.status = 1'b1;
            stre_pkg::RES_OK:   w_res = '0;
            stre_pkg::RES_READ: w_res.result_value = r_rdata;
            stre_pkg::RES_MAX: begin
                w_res.result_value = r_best;
                w_res.result_index = r_bidx;
                w_res.found        = 1'b1;
                w_res.not_positive = (r_best <= 0);
            end
            stre_pkg::RES_RATIO: begin
                if (r_have) begin
                    w_res.result_value = r_best;
                    w_res.result_index = r_bidx;
                    w_res.found        = 1'b1;
                end
            end
            default: w_res.status = 1'b1;
        endcase
    end

    always_comb begin
        o_sts.cmd        = r_req.command;
        o_sts.ok_rc      = w_row_ok && w_col_ok;
        o_sts.ok_div     = (r_req.operand_value != 0) && w_row_ok;
        o_sts.op_one     = (r_req.operand_value == ONE);
        o_sts.ok_elim    = w_row_ok && w_prow_ok && w_col_ok;
        o_sts.ok_am      = w_row_ok && (w_nc != '0);
        o_sts.ok_rt      = w_col_ok && w_dcol_ok;
        o_sts.idx_lt_nc  = (i_cmd.idx < w_nc);
        o_sts.idx_lt_nr  = (i_cmd.idx < {1'b0, w_nr});
        o_sts.idx_is_obj = (i_cmd.idx == {2'b00, r_obj_row});
        o_sts.rd_zero    = (r_rdata == 0);
        o_sts.y_le0      = (r_y <= 0);
        o_sts.div_done   = w_div_done;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= stre_pkg::NR_W'(16);
            r_num_cols <= stre_pkg::NC_W'(32);
            r_obj_row  <= stre_pkg::OBJ_W'(15);
            r_have     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    stre_pkg::CFG_NUM_ROWS: r_num_rows <= i_cfg_data[stre_pkg::NR_W-1:0];
                    stre_pkg::CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                    stre_pkg::CFG_OBJ_ROW:  r_obj_row  <= i_cfg_data[stre_pkg::OBJ_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_best) begin
                r_have <= 1'b0;
                r_best <= '0;
                r_bidx <= '0;
            end
            if (i_cmd.upd_max) begin
                if ((i_cmd.idx == '0) || (r_rdata > r_best)) begin
                    r_best <= r_rdata;
                    r_bidx <= i_cmd.idx[stre_pkg::RIDX_W-1:0];
                end
            end
            if (i_cmd.upd_rat) begin
                if ((w_cand > 0) && (!r_have || (w_cand < r_best))) begin
                    r_best <= w_cand;
                    r_bidx <= i_cmd.idx[stre_pkg::RIDX_W-1:0];
                    r_have <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req)  r_req  <= i_in_data;
        if (i_cmd.ld_x)    r_x    <= r_rdata;
        if (i_cmd.ld_y)    r_y    <= r_rdata;
        if (i_cmd.ld_y_op) r_y    <= r_req.operand_value;
        if (i_cmd.ld_m)    r_m    <= r_rdata;
        if (i_cmd.mul)     r_prod <= r_x * r_m;
        if (i_cmd.res_ld)  r_out  <= w_res;
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/stre_ctrl.sv =====
`default_nettype none

module stre_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire stre_pkg::t_dp_sts  i_sts,
    output stre_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DEC, S_RDE,
        S_DV_CHK, S_DV_LA, S_DV_GO, S_DV_WT,
        S_EL_ML, S_EL_CHK, S_EL_LP, S_EL_MUL, S_EL_WR,
        S_AM_CHK, S_AM_LA,
        S_RT_CHK, S_RT_LD, S_RT_LN, S_RT_CMP, S_RT_GO, S_RT_WT,
        S_RESP
    } t_state;

    localparam int IW = stre_pkg::IDX_W;

    t_state                          r_state, n_state;
    logic [IW-1:0]                   r_idx, n_idx;
    logic [stre_pkg::ADDR_W-1:0]     r_clr, n_clr;
    stre_pkg::t_res                  r_kind, n_kind;
    logic                            r_out_valid, n_out_valid;
    stre_pkg::t_dp_cmd               w_cmd;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_clr       = r_clr;
        n_kind      = r_kind;
        n_out_valid = r_out_valid;
        w_cmd          = '0;
        w_cmd.idx      = r_idx;
        w_cmd.clr_addr = r_clr;
        w_cmd.res_kind = r_kind;

        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        unique case (r_state)
            S_CLR: begin
                w_cmd.mem_wr   = 1'b1;
                w_cmd.addr_sel = stre_pkg::AS_CLR;
                w_cmd.wr_sel   = stre_pkg::WS_ZERO;
                n_clr = r_clr + stre_pkg::ADDR_W'(1);
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                w_cmd.ld_req = i_in_valid;
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                n_idx   = '0;
                n_kind  = stre_pkg::RES_ERR;
                n_state = S_RESP;
                unique case (i_sts.cmd)
                    stre_pkg::OP_WRITE: begin
                        if (i_sts.ok_rc) begin
                            w_cmd.mem_wr   = 1'b1;
                            w_cmd.addr_sel = stre_pkg::AS_RC;
                            w_cmd.wr_sel   = stre_pkg::WS_OP;
                            n_kind         = stre_pkg::RES_OK;
                        end
                    end
                    stre_pkg::OP_READ: begin
                        if (i_sts.ok_rc) begin
                            w_cmd.mem_rd   = 1'b1;
                            w_cmd.addr_sel = stre_pkg::AS_RC;
                            n_state        = S_RDE;
                        end
                    end
                    stre_pkg::OP_DIV: begin
                        if (i_sts.ok_div && i_sts.op_one) begin
                            n_kind = stre_pkg::RES_OK;
                        end else if (i_sts.ok_div) begin
                            w_cmd.ld_y_op = 1'b1;
                            n_state       = S_DV_CHK;
                        end
                    end
                    stre_pkg::OP_ELIM: begin
                        if (i_sts.ok_elim) begin
                            w_cmd.mem_rd   = 1'b1;
                            w_cmd.addr_sel = stre_pkg::AS_RC;
                            n_state        = S_EL_ML;
                        end
                    end
                    stre_pkg::OP_MAX: begin
                        if (i_sts.ok_am) begin
                            w_cmd.clr_best = 1'b1;
                            n_state        = S_AM_CHK;
                        end
                    end
                    stre_pkg::OP_RATIO: begin
                        if (i_sts.ok_rt) begin
                            w_cmd.clr_best = 1'b1;
                            n_state        = S_RT_CHK;
                        end
                    end
                    default: n_kind = stre_pkg::RES_ERR;
                endcase
            end
            S_RDE: begin
                n_kind  = stre_pkg::RES_READ;
                n_state = S_RESP;
            end
            S_DV_CHK: begin
                if (i_sts.idx_lt_nc) begin
                    w_cmd.mem_rd   = 1'b1;
                    w_cmd.addr_sel = stre_pkg::AS_RI;
                    n_state        = S_DV_LA;
                end else begin
                    n_kind  = stre_pkg::RES_OK;
                    n_state = S_RESP;
                end
            end
            S_DV_LA: begin
                if (i_sts.rd_zero) begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_DV_CHK;
                end else begin
                    w_cmd.ld_x = 1'b1;
                    n_state    = S_DV_GO;
                end
            end
            S_DV_GO: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DV_WT;
            end
            S_DV_WT: begin
                if (i_sts.div_done) begin
                    w_cmd.mem_wr   = 1'b1;
                    w_cmd.addr_sel = stre_pkg::AS_RI;
                    w_cmd.wr_sel   = stre_pkg::WS_DIV;
                    n_idx          = r_idx + IW'(1);
                    n_state        = S_DV_CHK;
                end
            end
            S_EL_ML: begin
                w_cmd.ld_m = 1'b1;
                n_state    = S_EL_CHK;
            end
            S_EL_CHK: begin
                if (i_sts.idx_lt_nc) begin
                    w_cmd.mem_rd   = 1'b1;
                    w_cmd.addr_sel = stre_pkg::AS_PI;
                    n_state        = S_EL_LP;
                end else begin
                    n_kind  = stre_pkg::RES_OK;
                    n_state = S_RESP;
                end
            end
            S_EL_LP: begin
                if (i_sts.rd_zero) begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_EL_CHK;
                end else begin
                    w_cmd.ld_x     = 1'b1;
                    w_cmd.mem_rd   = 1'b1;
                    w_cmd.addr_sel = stre_pkg::AS_RI;
                    n_state        = S_EL_MUL;
                end
            end
            S_EL_MUL: begin
                w_cmd.ld_y = 1'b1;
                w_cmd.mul  = 1'b1;
                n_state    = S_EL_WR;
            end
            S_EL_WR: begin
                w_cmd.mem_wr   = 1'b1;
                w_cmd.addr_sel = stre_pkg::AS_RI;
                w_cmd.wr_sel   = stre_pkg::WS_ELIM;
                n_idx          = r_idx + IW'(1);
                n_state        = S_EL_CHK;
            end
            S_AM_CHK: begin
                if (i_sts.idx_lt_nc) begin
                    w_cmd.mem_rd   = 1'b1;
                    w_cmd.addr_sel = stre_pkg::AS_RI;
                    n_state        = S_AM_LA;
                end else begin
                    n_kind  = stre_pkg::RES_MAX;
                    n_state = S_RESP;
                end
            end
            S_AM_LA: begin
                w_cmd.upd_max = 1'b1;
                n_idx         = r_idx + IW'(1);
                n_state       = S_AM_CHK;
            end
            S_RT_CHK: begin
                if (!i_sts.idx_lt_nr) begin
                    n_kind  = stre_pkg::RES_RATIO;
                    n_state = S_RESP;
                end else if (i_sts.idx_is_obj) begin
                    n_idx = r_idx + IW'(1);
                end else begin
                    w_cmd.mem_rd   = 1'b1;
                    w_cmd.addr_sel = stre_pkg::AS_ID;
                    n_state        = S_RT_LD;
                end
            end
            S_RT_LD: begin
                w_cmd.ld_y     = 1'b1;
                w_cmd.mem_rd   = 1'b1;
                w_cmd.addr_sel = stre_pkg::AS_IC;
                n_state        = S_RT_LN;
            end
            S_RT_LN: begin
                w_cmd.ld_x = 1'b1;
                n_state    = i_sts.y_le0 ? S_RT_CMP : S_RT_GO;
            end
            S_RT_CMP: begin
                w_cmd.upd_rat = 1'b1;
                n_idx         = r_idx + IW'(1);
                n_state       = S_RT_CHK;
            end
            S_RT_GO: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_RT_WT;
            end
            S_RT_WT: begin
                if (i_sts.div_done) begin
                    w_cmd.upd_rat = 1'b1;
                    w_cmd.rat_div = 1'b1;
                    n_idx         = r_idx + IW'(1);
                    n_state       = S_RT_CHK;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.res_ld = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_clr       <= '0;
            r_kind      <= stre_pkg::RES_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_clr       <= n_clr;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/simplex_tableau_row_engine.sv =====
// Channel   Dir  Handshake                    Payload
// in        in   i_in_valid / o_in_ready      i_in_data   (stre_pkg::t_in)
// out       out  o_out_valid / i_out_ready    o_out_data  (stre_pkg::t_out)
// cfg       in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// After reset a sweep zeroes the tableau; no command is taken meanwhile (cfg writes are).
// One command at a time. Argmax reads each column in turn; eliminate skips zero pivot
// columns and reads, multiplies and writes back the others. Divide row and ratio test
// run the 48-step divider per nonzero entry and per positive-denominator row.
// A finished result sits in the output register while the next command is taken.
// cfg is always ready.
`default_nettype none
`include "assert_macros.svh"

module simplex_tableau_row_engine (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire stre_pkg::t_in                       i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output stre_pkg::t_out                           o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [stre_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [stre_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    stre_pkg::t_dp_cmd w_cmd;
    stre_pkg::t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    stre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    stre_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

    `STRE_ASSERT_NEXT(a_leave_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input accepted but engine stayed idle")
    `STRE_ASSERT_IMPL(a_res_free, i_clk, i_rst_n, w_cmd.res_ld, !o_out_valid || i_out_ready, "result loaded over a pending one")
    `STRE_ASSERT_IMPL(a_rd_wr, i_clk, i_rst_n, w_cmd.mem_wr, !w_cmd.mem_rd, "tableau read and write in one cycle")
    `STRE_ASSERT_IMPL(a_rose_ld, i_clk, i_rst_n, $rose(o_out_valid), $past(w_cmd.res_ld), "output valid without a result load")

endmodule

`default_nettype wire
